@@ hw/rtl/sas_pkg.sv @@
// Package with shared types and constants of the signed array sorter.
package sas_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int DEPTH_DEFAULT = 64;

  // Input transaction
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last_item;
  } item_t;

  // Output transaction
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         final_result;
    logic                         overflowed;
  } result_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic                         insert;
    logic                         shift;
    logic signed [DATA_WIDTH-1:0] value;
  } cell_ctrl_t;

  // What a cell shows to its neighbors
  typedef struct packed {
    logic                         valid;
    logic                         take;
    logic signed [DATA_WIDTH-1:0] value;
  } cell_link_t;

  typedef enum logic {
    PH_LOAD,
    PH_DRAIN
  } phase_t;

endpackage

@@ hw/rtl/sas_cell.sv @@
// One cell of the insertion chain: holds one element and its valid bit.
module sas_cell
  import sas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic signed [DATA_WIDTH-1:0] value;
  logic                         valid;
  logic                         take;

  // Mark this cell at or past the insertion point
  assign take = !valid || ($signed(value) > $signed(ctrl.value));

  assign link.valid = valid;
  assign link.take  = take;
  assign link.value = value;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= right.valid;
    end else if (ctrl.insert) begin
      valid <= valid | left.valid;
    end
  end

  // Shift right to open a slot, drop the new element in, or advance toward the output
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= right.value;
    end else if (ctrl.insert) begin
      if (left.take) begin
        value <= left.value;
      end else if (take) begin
        value <= ctrl.value;
      end
    end
  end

endmodule

@@ hw/rtl/signed_array_sorter.sv @@
// Top level of the signed array sorter: a chain of insertion cells and its control.
//
// Elements enter one per cycle while loading and are inserted in ascending order
// into a chain of DEPTH cells; each cell compares the incoming element with its own
// and takes either it or its left neighbor's element. The transaction marked
// last_item is stored too, then the chain shifts toward cell 0 and delivers one
// result per cycle while result_stall is low, smallest first. The item side stalls
// from the cycle after the last item until the final result is taken.
// Elements arriving while all cells are full are dropped, and overflowed is set on
// every result of that set.
module signed_array_sorter
  import sas_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  phase_t     phase;
  phase_t     phase_next;
  logic       overflow;
  logic       overflow_next;
  logic       item_accept;
  logic       result_accept;
  logic       full;
  cell_ctrl_t ctrl;
  cell_link_t lnk [0:DEPTH+1];

  assign item_stall    = (phase == PH_DRAIN);
  assign item_accept   = item_valid && !item_stall;
  assign result_valid  = (phase == PH_DRAIN) && lnk[1].valid;
  assign result_accept = result_valid && !result_stall;
  assign full          = lnk[DEPTH].valid;

  // Broadcast the command to the chain
  assign ctrl.insert = item_accept && !full;
  assign ctrl.shift  = result_accept;
  assign ctrl.value  = item.value;

  // Tie off both ends of the chain
  assign lnk[0]       = '{valid: 1'b1, take: 1'b0, value: '0};
  assign lnk[DEPTH+1] = '{valid: 1'b0, take: 1'b1, value: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sas_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (lnk[i]),
      .right (lnk[i+2]),
      .link  (lnk[i+1])
    );
  end

  // Present the head of the chain
  assign result.sorted_value = lnk[1].value;
  assign result.final_result = !lnk[2].valid;
  assign result.overflowed   = overflow;

  // Hold phase and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOAD;
      overflow <= 1'b0;
    end else begin
      phase    <= phase_next;
      overflow <= overflow_next;
    end
  end

  // Load until the last item, then drain until the final result is taken
  always_comb begin
    phase_next    = phase;
    overflow_next = overflow;
    case (phase)
      PH_LOAD: begin
        if (item_accept) begin
          if (full) begin
            overflow_next = 1'b1;
          end
          if (item.last_item) begin
            phase_next = PH_DRAIN;
          end
        end
      end
      PH_DRAIN: begin
        if (result_accept && result.final_result) begin
          phase_next    = PH_LOAD;
          overflow_next = 1'b0;
        end
      end
      default: begin
        phase_next = PH_LOAD;
      end
    endcase
  end

endmodule
